FILE: rtl/usswr_pkg.sv
// usswr_pkg: shared constants, codes and types of the unordered set unit
// used by usswr_cell, usswr_mod and unordered_set_swap_remove_unit
`default_nettype none

package usswr_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 6;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RND_W    = 16;
  localparam int RND_CW   = $clog2(RND_W);
  localparam int ACT_W    = 2;
  localparam int ST_W     = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_PICKUP = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  // settings broadcast to every cell, stable for a whole scan
  typedef struct packed {
    logic             pick_mode;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] sel_slot;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] last_slot;
  } scan_cmd_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] hkey;
    logic [KEY_W-1:0] last;
  } probe_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] key;
  } wr_t;

endpackage

`default_nettype wire

FILE: rtl/unordered_set_swap_remove_unit.sv
// unordered_set_swap_remove_unit: set of keys in an unordered slot row with swap removal
// Input channel: in_valid/in_ready with action, key, position, use_random and
// random_value. Output channel: out_valid/out_ready with status,
// found_position, key_out and entry_count. One result beat per input beat.
// Insert, remove and locate run a scan wave down a row of 64 cells, one cell
// per cycle, then a resolve state. Pickup first reduces its position, or
// random_value when use_random is set, modulo the count in a bit-serial unit
// and then scans. A pickup on an empty set goes straight from idle to resolve.
// Removal copies the last entry into the freed slot in the resolve cycle.
// in_ready is high only while no item is in progress; a new item may be
// accepted while the previous result still waits in the output register.
// If the receiver stalls, the finished item holds in resolve until the output
// register frees, and no slot is written before then.
// Reset empties the set (count zero); slot contents need no clearing since
// only slots below the count are ever read.
// depends on usswr_pkg, usswr_cell, usswr_mod
`default_nettype none

module unordered_set_swap_remove_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [usswr_pkg::ACT_W-1:0]   action,
  input  wire  [usswr_pkg::KEY_W-1:0]   key,
  input  wire  [usswr_pkg::IDX_W-1:0]   position,
  input  wire                           use_random,
  input  wire  [usswr_pkg::RND_W-1:0]   random_value,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [usswr_pkg::ST_W-1:0]    status,
  output logic [usswr_pkg::IDX_W-1:0]   found_position,
  output logic [usswr_pkg::KEY_W-1:0]   key_out,
  output logic [usswr_pkg::CNT_W-1:0]   entry_count
);
  import usswr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_MOD     = 4'b0010,
    S_SCAN    = 4'b0100,
    S_RESOLVE = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [ACT_W-1:0] act;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] sel_slot;
  logic [IDX_W-1:0] scan_cnt;

  logic             accept;
  logic             out_free;
  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;
  logic [CNT_W-1:0] cnt_m1;

  scan_cmd_t        cmd;
  wr_t              wr;
  probe_t           chain [CAPACITY+1];
  probe_t           fin;

  logic [ST_W-1:0]  res_status;
  logic [IDX_W-1:0] res_slot;
  logic [KEY_W-1:0] res_key;
  logic [CNT_W-1:0] res_count;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign mod_start = accept && action == ACT_PICKUP && count != '0;
  assign cnt_m1    = count - CNT_W'(1);

  assign cmd.pick_mode = (act == ACT_PICKUP);
  assign cmd.key       = key_q;
  assign cmd.sel_slot  = sel_slot;
  assign cmd.count     = count;
  assign cmd.last_slot = cnt_m1[IDX_W-1:0];

  usswr_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (use_random ? random_value : RND_W'(position)),
    .divisor   (count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    usswr_cell u_cell (
      .clk        (clk),
      .cell_index (IDX_W'(g)),
      .cmd        (cmd),
      .wr         (wr),
      .probe_in   (chain[g]),
      .probe_out  (chain[g+1])
    );
  end

  assign fin = chain[CAPACITY];

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_key    = '0;
    res_count  = count;
    wr         = '0;
    case (act) inside
      ACT_INSERT: begin
        if (fin.hit) begin
          res_status = ST_DUP;
          res_slot   = fin.slot;
          res_key    = key_q;
        end else if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          res_slot  = count[IDX_W-1:0];
          res_key   = key_q;
          res_count = count + CNT_W'(1);
          wr.en     = 1'b1;
          wr.slot   = count[IDX_W-1:0];
          wr.key    = key_q;
        end
      end
      ACT_REMOVE, ACT_LOCATE: begin
        if (fin.hit) begin
          res_slot = fin.slot;
          res_key  = key_q;
          if (act == ACT_REMOVE) begin
            res_count = cnt_m1;
            wr.en     = 1'b1;
            wr.slot   = fin.slot;
            wr.key    = fin.last;
          end
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_slot  = sel_slot;
          res_key   = fin.hkey;
          res_count = cnt_m1;
          wr.en     = 1'b1;
          wr.slot   = sel_slot;
          wr.key    = fin.last;
        end
      end
    endcase
    // slot write only when the result is handed over
    wr.en = wr.en && state == S_RESOLVE && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      if (state == S_RESOLVE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_cnt <= '0;
            if (action != ACT_PICKUP) begin
              state <= S_SCAN;
            end else if (count == '0) begin
              state <= S_RESOLVE;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == IDX_W'(CAPACITY - 1)) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (out_free) begin
            count <= res_count;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action;
      key_q <= key;
    end
    if (state == S_MOD && mod_done) begin
      sel_slot <= mod_rem;
    end
    if (state == S_RESOLVE && out_free) begin
      status         <= res_status;
      found_position <= res_slot;
      key_out        <= res_key;
      entry_count    <= res_count;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  a_out_from_resolve: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESOLVE))
    else $error("result beat raised outside resolve");

  a_count_only_on_resolve: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> $past(state == S_RESOLVE))
    else $error("entry count changed outside resolve");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("remainder done outside modulo state");

endmodule

`default_nettype wire

FILE: rtl/usswr_cell.sv
// usswr_cell: one slot of the set plus one registered step of the scan chain
// depends on usswr_pkg
`default_nettype none

module usswr_cell (
  input  wire                          clk,
  input  wire  [usswr_pkg::IDX_W-1:0]  cell_index,
  input  usswr_pkg::scan_cmd_t         cmd,
  input  usswr_pkg::wr_t               wr,
  input  usswr_pkg::probe_t            probe_in,
  output usswr_pkg::probe_t            probe_out
);
  import usswr_pkg::*;

  logic [KEY_W-1:0] entry;
  logic             in_range;
  logic             match;

  assign in_range = {1'b0, cell_index} < cmd.count;
  assign match    = cmd.pick_mode ? (cell_index == cmd.sel_slot)
                                  : (in_range && entry == cmd.key);

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == cell_index) begin
      entry <= wr.key;
    end
  end

  // first hit along the chain wins
  always_ff @(posedge clk) begin
    probe_out.hit  <= probe_in.hit | match;
    probe_out.slot <= probe_in.hit ? probe_in.slot : cell_index;
    probe_out.hkey <= probe_in.hit ? probe_in.hkey : entry;
    probe_out.last <= (cell_index == cmd.last_slot) ? entry : probe_in.last;
  end

endmodule

`default_nettype wire

FILE: rtl/usswr_mod.sv
// usswr_mod: bit-serial remainder of a 16-bit value by the entry count
// depends on usswr_pkg
`default_nettype none

module usswr_mod (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [usswr_pkg::RND_W-1:0]  dividend,
  input  wire  [usswr_pkg::CNT_W-1:0]  divisor,
  output logic                         done,
  output logic [usswr_pkg::IDX_W-1:0]  remainder
);
  import usswr_pkg::*;

  logic              busy;
  logic [RND_CW-1:0] step;
  logic [RND_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;

  assign trial     = {rem, dvd[RND_W-1]};
  assign remainder = rem[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == RND_CW'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so one compare and subtract per bit
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= CNT_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/unordered_set_swap_remove_unit_tb.sv
// unordered_set_swap_remove_unit_tb: checks the unordered key set with swap removal
// against a tracked copy of the slot row, under random bursts and output stalls
// depends on usswr_pkg and unordered_set_swap_remove_unit
`timescale 1ns / 100ps

module unordered_set_swap_remove_unit_tb;
  import usswr_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } set_result_t;

  class key_set_tracker;
    logic [KEY_W-1:0] slots [CAPACITY];
    int fill;
    set_result_t pending_replies [$];
    int errors;
    int checked;
    int peak_fill;
    int act_seen [4];
    int status_seen [8];

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < fill; i++)
        if (slots[i] == k) return i;
      return -1;
    endfunction

    // last entry moves into the freed slot
    function void drop_at(int s);
      slots[s] = slots[fill-1];
      fill--;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                               logic [IDX_W-1:0] pos, logic use_rnd,
                               logic [RND_W-1:0] rnd);
      set_result_t r;
      int s;
      r = '0;
      r.status = ST_OK;
      case (act)
        ACT_INSERT: begin
          s = find_key(k);
          if (s >= 0) begin
            r.status = ST_DUP;
            r.slot = IDX_W'(s);
            r.key = k;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = k;
            r.slot = IDX_W'(fill);
            r.key = k;
            fill++;
          end
        end
        ACT_REMOVE, ACT_LOCATE: begin
          s = find_key(k);
          if (s >= 0) begin
            r.slot = IDX_W'(s);
            r.key = k;
            if (act == ACT_REMOVE) drop_at(s);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            s = (use_rnd ? int'(rnd) : int'(pos)) % fill;
            r.slot = IDX_W'(s);
            r.key = slots[s];
            drop_at(s);
          end
        end
      endcase
      r.count = CNT_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      act_seen[act]++;
      status_seen[r.status]++;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(set_result_t got);
      set_result_t want;
      if (pending_replies.size() == 0) begin
        $error("result beat with nothing pending: status %0d slot %0d key %0d count %0d",
               got.status, got.slot, got.key, got.count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot != want.slot) begin
        $error("found_position: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.key != want.key) begin
        $error("key_out: expected %0d, got %0d", want.key, got.key);
        errors++;
      end
      if (got.count != want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  position;
  logic              use_random;
  logic [RND_W-1:0]  random_value;
  logic              out_valid;
  logic              out_ready;
  logic [ST_W-1:0]   status;
  logic [IDX_W-1:0]  found_position;
  logic [KEY_W-1:0]  key_out;
  logic [CNT_W-1:0]  entry_count;

  key_set_tracker tracker;
  int burst_left;
  int idle_cycles;

  unordered_set_swap_remove_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .key            (key),
    .position       (position),
    .use_random     (use_random),
    .random_value   (random_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .key_out        (key_out),
    .entry_count    (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_reply('{status, found_position, key_out, entry_count});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("unordered_set_swap_remove_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver: stretches of steady, random, sparse or stalled ready that frees only at the end
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = (i >= span - 4);
        endcase
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] a, input logic [KEY_W-1:0] k,
                           input logic [IDX_W-1:0] p, input logic u,
                           input logic [RND_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    action = a;
    key = k;
    position = p;
    use_random = u;
    random_value = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(a, k, p, u, r);
  endtask

  // fields the action does not use still carry random values
  task automatic send_op(input logic [ACT_W-1:0] a, input logic [KEY_W-1:0] k);
    send_item(a, k, IDX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
              RND_W'($urandom_range(0, 65535)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int roll;
    int ins_cut;
    int share;
    logic [ACT_W-1:0] a;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    // lean toward inserts while the set is small and removals while it is large
    ins_cut = (tracker.fill < 16) ? 55 : (tracker.fill > 48) ? 15 : 35;
    share = (100 - ins_cut) / 3;
    if (roll < ins_cut) a = ACT_INSERT;
    else if (roll < ins_cut + share) a = ACT_REMOVE;
    else if (roll < ins_cut + 2 * share) a = ACT_LOCATE;
    else a = ACT_PICKUP;
    if (tracker.fill > 0 &&
        $urandom_range(0, 99) < ((a == ACT_INSERT) ? 25 : 65))
      k = tracker.slots[$urandom_range(0, tracker.fill - 1)];
    else
      k = KEY_W'($urandom_range(0, 63));
    send_op(a, k);
  endtask

  // every key in shuffled order, then empty the set again by pickups and removals
  task automatic fill_then_drain();
    int order [CAPACITY];
    int j;
    int t;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < CAPACITY; i++) order[i] = i;
    for (int i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < CAPACITY; i++)
      if (tracker.find_key(KEY_W'(order[i])) < 0)
        send_op(ACT_INSERT, KEY_W'(order[i]));
    // with every key present, a further insert can only be a duplicate
    send_op(ACT_INSERT, KEY_W'($urandom_range(0, 63)));
    send_op(ACT_LOCATE, KEY_W'($urandom_range(0, 63)));
    while (tracker.fill > 0) begin
      k = tracker.slots[$urandom_range(0, tracker.fill - 1)];
      if ($urandom_range(0, 4) == 0) send_op(ACT_REMOVE, k);
      else send_op(ACT_PICKUP, k);
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_INSERT;
    key = '0;
    position = '0;
    use_random = 1'b0;
    random_value = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty set first
    send_item(ACT_PICKUP, 6'd0, 6'd63, 1'b0, 16'h0000);
    send_item(ACT_PICKUP, 6'd63, 6'd0, 1'b1, 16'hFFFF);
    send_item(ACT_REMOVE, 6'd5, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_LOCATE, 6'd5, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd0, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd63, 6'd63, 1'b1, 16'hFFFF);
    send_item(ACT_INSERT, 6'd42, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd63, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_LOCATE, 6'd63, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_LOCATE, 6'd7, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_REMOVE, 6'd7, 6'd0, 1'b0, 16'h0000);
    // removal from the first slot pulls the last key forward
    send_item(ACT_REMOVE, 6'd0, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_LOCATE, 6'd42, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_REMOVE, 6'd63, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd21, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_PICKUP, 6'd0, 6'd63, 1'b0, 16'h0000);
    send_item(ACT_PICKUP, 6'd0, 6'd0, 1'b1, 16'hFFFF);
    send_item(ACT_PICKUP, 6'd0, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd10, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd11, 6'd0, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 6'd12, 6'd0, 1'b0, 16'h0000);
    // random pickup ignores the position field
    send_item(ACT_PICKUP, 6'd0, 6'd63, 1'b1, 16'h8000);
    send_item(ACT_PICKUP, 6'd0, 6'd0, 1'b0, 16'hFFFF);
    send_item(ACT_LOCATE, 6'd63, 6'd0, 1'b0, 16'h0000);

    // hold off until every result of the directed beats is back
    drain();

    repeat (130) random_item();
    fill_then_drain();
    repeat (130) random_item();
    fill_then_drain();
    repeat (130) random_item();

    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d beats: %0d insert, %0d remove, %0d locate, %0d pickup, peak fill %0d",
             tracker.checked, tracker.act_seen[ACT_INSERT], tracker.act_seen[ACT_REMOVE],
             tracker.act_seen[ACT_LOCATE], tracker.act_seen[ACT_PICKUP], tracker.peak_fill);
    $display("status mix: %0d ok, %0d duplicate, %0d not found, %0d empty, %0d full",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_DUP],
             tracker.status_seen[ST_NOTFOUND], tracker.status_seen[ST_EMPTY],
             tracker.status_seen[ST_FULL]);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("unordered_set_swap_remove_unit: match");
    end else begin
      $display("unordered_set_swap_remove_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/usswr_pkg.sv
rtl/usswr_cell.sv
rtl/usswr_mod.sv
rtl/unordered_set_swap_remove_unit.sv
sim/unordered_set_swap_remove_unit_tb.sv
